// ===== sv/mrt_pkg.sv =====
`default_nettype none
package mrt_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_SETHOP = 3'd1;
  localparam logic [2:0] KIND_LOOKUP = 3'd2;
  localparam logic [2:0] KIND_EXISTS = 3'd3;
  localparam logic [2:0] KIND_REMOVE = 3'd4;
  localparam logic [2:0] KIND_CLEAR  = 3'd5;

  localparam logic [2:0] ST_ACTIVE     = 3'd0;
  localparam logic [2:0] ST_FAILED     = 3'd2;
  localparam logic [2:0] ST_VALIDATING = 3'd4;

  localparam logic [15:0] NO_HOP = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] dst_node;
    logic [2:0]  new_status;
    logic [15:0] hop_addr;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] fwd_hop;
    logic        table_full;
  } res_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] dest;
    logic [15:0] hop;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/mesh_route_table_unit.sv =====
`default_nettype none
// Route table with TABLE_ENTRIES slots. An operation is taken when start is
// high and busy is low; its result appears on out_item for one cycle with
// out_valid high and must be taken then, since the receiver cannot stall.
// Table operations scan the entry memory one slot per cycle through its
// single read port, stopping at the first matching entry; the result strobe
// comes from the S_WRITE state once the scan ends, and busy drops in the
// cycle the strobe is shown, so the next operation may be taken then.
// clear_all and unknown kinds give their result on the next cycle and never
// raise busy.
module mesh_route_table_unit #(
  parameter int TABLE_ENTRIES = mrt_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire mrt_pkg::req_t in_item,
  output logic               busy,
  output logic               out_valid,
  output mrt_pkg::res_t      out_item
);
  import mrt_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  mrt_ctrl #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  mrt_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule
`default_nettype wire

// ===== sv/mrt_mem.sv =====
`default_nettype none
module mrt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire logic [AW-1:0]  wr_addr,
  input  wire mrt_pkg::entry_t wr_data,
  input  wire logic           rd_en,
  input  wire logic [AW-1:0]  rd_addr,
  output mrt_pkg::entry_t     rd_data
);
  import mrt_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== sv/mrt_ctrl.sv =====
`default_nettype none
module mrt_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire mrt_pkg::req_t   in_item,
  output logic                 busy,
  output logic                 out_valid,
  output mrt_pkg::res_t        out_item,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output mrt_pkg::entry_t      mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  wire mrt_pkg::entry_t mem_rdata
);
  import mrt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [1:0]       state_r;
  req_t             req_r;
  logic [AW-1:0]    idx_r;
  logic             issue_done_r;
  logic             pend_r;
  logic [AW-1:0]    pend_idx_r;
  logic             match_r;
  logic [AW-1:0]    match_idx_r;
  entry_t           match_ent_r;
  logic             free_r;
  logic [AW-1:0]    free_idx_r;
  logic [DEPTH-1:0] valid_r;
  logic             out_valid_r;
  res_t             out_item_r;

  logic   accept;
  logic   hit;
  logic   usable;
  res_t   res;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign mem_re    = (state_r == S_SCAN) && !issue_done_r;
  assign mem_raddr = idx_r;

  // one compare per cycle against the entry read the cycle before
  assign hit    = pend_r && valid_r[pend_idx_r] && (mem_rdata.dest == req_r.dst_node);
  assign usable = (match_ent_r.status == ST_ACTIVE) || (match_ent_r.status == ST_VALIDATING);

  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = match_idx_r;
    mem_wdata      = match_ent_r;
    res.found      = match_r;
    res.fwd_hop    = NO_HOP;
    res.table_full = 1'b0;
    case (req_r.kind)
      KIND_ADD: begin
        if (match_r) begin
          mem_we           = 1'b1;
          mem_wdata.status = req_r.new_status;
        end else if (free_r) begin
          mem_we           = 1'b1;
          mem_waddr        = free_idx_r;
          mem_wdata.status = req_r.new_status;
          mem_wdata.dest   = req_r.dst_node;
          mem_wdata.hop    = '0;
        end else begin
          res.table_full = 1'b1;
        end
      end
      KIND_SETHOP: begin
        if (match_r) begin
          mem_we        = 1'b1;
          mem_wdata.hop = req_r.hop_addr;
        end
      end
      KIND_LOOKUP: begin
        if (match_r && usable) begin
          mem_we           = 1'b1;
          mem_wdata.status = ST_ACTIVE;
          res.fwd_hop      = match_ent_r.hop;
        end
      end
      default: ;
    endcase
    if (state_r != S_WRITE) begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
      issue_done_r <= 1'b0;
      match_r      <= 1'b0;
      free_r       <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r        <= in_item;
            idx_r        <= '0;
            issue_done_r <= 1'b0;
            pend_r       <= 1'b0;
            match_r      <= 1'b0;
            free_r       <= 1'b0;
            if (in_item.kind <= KIND_REMOVE) begin
              state_r <= S_SCAN;
            end else begin
              // clear_all and unknown kinds finish at once
              if (in_item.kind == KIND_CLEAR) begin
                valid_r <= '0;
              end
              out_valid_r           <= 1'b1;
              out_item_r.found      <= 1'b0;
              out_item_r.fwd_hop    <= NO_HOP;
              out_item_r.table_full <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            idx_r <= idx_r + 1'b1;
            if (idx_r == LAST) begin
              issue_done_r <= 1'b1;
            end
          end
          pend_r     <= mem_re;
          pend_idx_r <= idx_r;
          if (pend_r) begin
            if (hit) begin
              match_r     <= 1'b1;
              match_idx_r <= pend_idx_r;
              match_ent_r <= mem_rdata;
              pend_r      <= 1'b0;
              state_r     <= S_WRITE;
            end else begin
              if (!valid_r[pend_idx_r] && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= pend_idx_r;
              end
              if (pend_idx_r == LAST) begin
                pend_r  <= 1'b0;
                state_r <= S_WRITE;
              end
            end
          end
        end
        S_WRITE: begin
          if (req_r.kind == KIND_ADD && !match_r && free_r) begin
            valid_r[free_idx_r] <= 1'b1;
          end
          if (req_r.kind == KIND_REMOVE && match_r) begin
            valid_r[match_idx_r] <= 1'b0;
          end
          out_valid_r <= 1'b1;
          out_item_r  <= res;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== sv/mrt_check.sv =====
`default_nettype none
module mrt_check (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire mrt_pkg::req_t in_item,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire mrt_pkg::res_t out_item
);
  import mrt_pkg::*;

  // a result strobe always ends the transaction
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == KIND_CLEAR) |=>
      (out_valid && !out_item.found && out_item.fwd_hop == NO_HOP && !out_item.table_full))
    else $error("clear_all result wrong");

  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind <= KIND_REMOVE) |=> (busy && !out_valid))
    else $error("table operation did not raise busy");

  a_hop_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.fwd_hop != NO_HOP) |-> out_item.found)
    else $error("next hop without entry");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.table_full) |-> (!out_item.found && out_item.fwd_hop == NO_HOP))
    else $error("table_full with match");

endmodule

bind mesh_route_table_unit mrt_check u_mrt_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_item   (in_item),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
